>>> src/rpt_pkg.sv
// rpt_pkg: shared types, register indexes and constants of the rc pwm throttle decoder
`default_nettype none

package rpt_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PERIOD_MIN      = 3'd0;
    localparam logic [2:0] CFG_PERIOD_MAX      = 3'd1;
    localparam logic [2:0] CFG_HIGH_MIN        = 3'd2;
    localparam logic [2:0] CFG_HIGH_MAX        = 3'd3;
    localparam logic [2:0] CFG_DEADBAND        = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_DUTY_FULL_SCALE = 3'd6;
    localparam logic [2:0] CFG_FIXED_DUTY_PCT  = 3'd7;

    // register reset values
    localparam logic [15:0] RST_PERIOD_MIN      = 16'd2040;
    localparam logic [15:0] RST_PERIOD_MAX      = 16'd25000;
    localparam logic [15:0] RST_HIGH_MIN        = 16'd1000;
    localparam logic [15:0] RST_HIGH_MAX        = 16'd2000;
    localparam logic [15:0] RST_DEADBAND        = 16'd50;
    localparam logic [15:0] RST_TIMEOUT_LIMIT   = 16'd1500;
    localparam logic [15:0] RST_DUTY_FULL_SCALE = 16'd1000;
    localparam logic [6:0]  RST_FIXED_DUTY_PCT  = 7'd0;

    // reciprocals for floor division of a 29-bit value: exact by 125, and by 25 below 2^21
    // x / 1000 = (x >> 3) / 125 = ((x >> 3) * ceil(2^36 / 125)) >> 36
    // x / 100  = (x >> 2) / 25  = ((x >> 2) * ceil(2^26 / 25))  >> 26
    localparam logic [29:0] RECIP_125 = 30'd549755814;
    localparam logic [29:0] RECIP_25  = 30'd2684355;

    typedef enum logic [1:0] {
        DUTY_KEEP,
        DUTY_ZERO,
        DUTY_SCALE
    } t_duty_op;

    typedef struct packed {
        logic [15:0] period_min;
        logic [15:0] period_max;
        logic [15:0] high_min;
        logic [15:0] high_max;
        logic [15:0] deadband;
        logic [15:0] timeout_limit;
        logic [15:0] duty_full_scale;
        logic [6:0]  fixed_duty_pct;
    } t_cfg;

    // per-transaction result fields that ride along the duty pipeline
    typedef struct packed {
        logic [15:0] throttle;
        logic        lost;
        t_duty_op    op;
    } t_meta;

    // first pipeline stage: state update result and duty multiplicand
    typedef struct packed {
        t_meta       meta;
        logic        sel_fixed;
        logic [15:0] num;
    } t_s1;

endpackage

`default_nettype wire

>>> src/rpt_ctrl.sv
// rpt_ctrl: decoder state (period flag, silence counter, throttle) and first pipeline stage
`default_nettype none

module rpt_ctrl import rpt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic        i_period_seen,
    input  wire logic [15:0] i_period_ticks,
    input  wire logic        i_high_seen,
    input  wire logic [15:0] i_high_ticks,
    input  wire logic        i_overcapture,
    input  wire logic        i_s1_adv,
    output t_s1              o_s1,
    output logic             o_s1_valid
);

    logic        r_period_ok;
    logic [15:0] r_silence;
    logic [15:0] r_throttle;
    logic        r_s1_valid;
    t_s1         r_s1;

    logic        n_period_ok;
    logic [15:0] n_silence;
    logic [15:0] n_throttle;
    t_s1         n_s1;

    logic        w_acc;
    logic        w_fixed;
    logic        w_period_in;
    logic        w_high_in;
    logic        w_high_ok;
    logic [15:0] w_thr_raw;
    logic [15:0] w_thr;

    assign o_ready = !r_s1_valid || i_s1_adv;
    assign w_acc   = i_valid && o_ready;
    assign w_fixed = (i_cfg.fixed_duty_pct != 7'd0);

    // window checks and throttle from high time
    assign w_period_in = !i_overcapture && (i_period_ticks >= i_cfg.period_min)
                         && (i_period_ticks <= i_cfg.period_max);
    assign w_high_in   = (i_high_ticks >= i_cfg.high_min) && (i_high_ticks <= i_cfg.high_max);
    assign w_thr_raw   = i_high_ticks - i_cfg.high_min;
    assign w_thr       = (w_thr_raw < i_cfg.deadband) ? 16'd0 : w_thr_raw;

    // next state for one transaction
    always_comb begin
        logic po;
        po                = r_period_ok;
        n_period_ok       = r_period_ok;
        n_silence         = r_silence;
        n_throttle        = r_throttle;
        w_high_ok         = 1'b0;
        n_s1.sel_fixed    = 1'b0;
        n_s1.num          = 16'd0;
        n_s1.meta.op      = DUTY_KEEP;
        if (!i_action) begin
            if (i_period_seen) begin
                po = w_period_in;
            end
            w_high_ok = i_high_seen && !i_overcapture && po && w_high_in;
            if (w_high_ok) begin
                n_throttle = w_thr;
                n_silence  = 16'd0;
                if (!w_fixed) begin
                    n_s1.meta.op = DUTY_SCALE;
                    n_s1.num     = w_thr;
                end
            end
            if (i_high_seen) begin
                po = 1'b0;
            end
            n_period_ok = po;
            if (w_fixed) begin
                n_silence      = 16'd0;
                n_s1.meta.op   = DUTY_SCALE;
                n_s1.sel_fixed = 1'b1;
                n_s1.num       = {9'd0, i_cfg.fixed_duty_pct};
            end
        end else begin
            if (!w_fixed) begin
                if (r_silence < i_cfg.timeout_limit) begin
                    n_silence = r_silence + 16'd1;
                end
                if (n_silence >= i_cfg.timeout_limit) begin
                    n_throttle   = 16'd0;
                    n_s1.meta.op = DUTY_ZERO;
                end
            end else begin
                n_silence = 16'd0;
            end
        end
        n_s1.meta.throttle = n_throttle;
        n_s1.meta.lost     = (n_silence >= i_cfg.timeout_limit);
    end

    // state registers and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ok <= 1'b0;
            r_silence   <= 16'd0;
            r_throttle  <= 16'd0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_period_ok <= n_period_ok;
                r_silence   <= n_silence;
                r_throttle  <= n_throttle;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1       = r_s1;
    assign o_s1_valid = r_s1_valid;

    // fixed duty mode keeps the silence counter cleared
    a_fixed_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_fixed) |=> (r_silence == 16'd0))
        else $error("silence counter not cleared in fixed duty mode");

    // a forced zero duty always comes with zero throttle and loss flagged
    a_zero_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.meta.op == DUTY_ZERO) |-> (r_s1.meta.throttle == 16'd0
        && r_s1.meta.lost))
        else $error("zero duty without zero throttle and loss");

endmodule

`default_nettype wire

>>> src/rpt_scale.sv
// rpt_scale: duty scaling pipeline, full scale product then reciprocal division
`default_nettype none

module rpt_scale import rpt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_s1         i_s1,
    input  wire logic        i_s1_valid,
    output logic             o_s1_adv,
    input  wire logic        i_s3_adv,
    output t_meta            o_s3_meta,
    output logic [22:0]      o_s3_quo,
    output logic             o_s3_valid
);

    logic        r_s2_valid;
    t_meta       r_s2_meta;
    logic        r_s2_fixed;
    logic [31:0] r_s2_prod;

    logic        r_s3_valid;
    t_meta       r_s3_meta;
    logic [22:0] r_s3_quo;

    logic        w_en2;
    logic        w_en3;
    logic [31:0] w_prod;
    logic [28:0] w_dividend;
    logic [29:0] w_recip;
    logic [58:0] w_mul;
    logic [22:0] w_quo;

    assign w_en3    = !r_s3_valid || i_s3_adv;
    assign w_en2    = !r_s2_valid || w_en3;
    assign o_s1_adv = w_en2;

    // numerator times full scale
    assign w_prod = 32'(i_s1.num) * 32'(i_cfg.duty_full_scale);

    // divide by 1000 or 100 through a reciprocal multiply
    assign w_dividend = r_s2_fixed ? r_s2_prod[30:2] : r_s2_prod[31:3];
    assign w_recip    = r_s2_fixed ? RECIP_25 : RECIP_125;
    assign w_mul      = 59'(w_dividend) * 59'(w_recip);
    assign w_quo      = r_s2_fixed ? w_mul[48:26] : w_mul[58:36];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_en2) begin
                r_s2_valid <= i_s1_valid;
            end
            if (w_en3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en2 && i_s1_valid) begin
            r_s2_meta  <= i_s1.meta;
            r_s2_fixed <= i_s1.sel_fixed;
            r_s2_prod  <= w_prod;
        end
        if (w_en3 && r_s2_valid) begin
            r_s3_meta <= r_s2_meta;
            r_s3_quo  <= w_quo;
        end
    end

    assign o_s3_meta  = r_s3_meta;
    assign o_s3_quo   = r_s3_quo;
    assign o_s3_valid = r_s3_valid;

    // percent times full scale stays inside the narrow reciprocal range
    a_fixed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_fixed) |-> (r_s2_prod[31:23] == 9'd0))
        else $error("fixed duty product out of range");

endmodule

`default_nettype wire

>>> src/rc_pwm_throttle_decoder.sv
// rc_pwm_throttle_decoder: top level, configuration registers and result register
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_ready  action, period_seen, period_ticks,
//                                          high_seen, high_ticks, overcapture
//  result    out        o_valid / i_ready  throttle, duty, signal_lost
//  config    in         i_cfg_we           i_cfg_idx, i_cfg_data (no read-back)
//
//  one transaction per cycle sustained while i_ready is high; a result reaches o_valid
//  through the state stage, the product stage, the division stage and the result register
//  the state update for each transaction finishes in the cycle it is taken
//  synchronous active low reset clears state, pipeline valids and restores registers
//  each stage moves up when the one after it is empty or moving, so bubbles close up
//  under a stalled result; o_ready drops once all four stages hold transactions
`default_nettype none

module rc_pwm_throttle_decoder import rpt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic        i_period_seen,
    input  wire logic [15:0] i_period_ticks,
    input  wire logic        i_high_seen,
    input  wire logic [15:0] i_high_ticks,
    input  wire logic        i_overcapture,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_throttle,
    output logic [15:0]      o_duty,
    output logic             o_signal_lost
);

    t_cfg        r_cfg;
    logic        r_o_valid;
    logic [15:0] r_o_throttle;
    logic [15:0] r_o_duty;
    logic        r_o_lost;

    logic [15:0] n_duty;

    t_s1         w_s1;
    logic        w_s1_valid;
    logic        w_s1_adv;
    t_meta       w_s3_meta;
    logic [22:0] w_s3_quo;
    logic        w_s3_valid;
    logic        w_out_en;
    logic [15:0] w_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_min      <= RST_PERIOD_MIN;
            r_cfg.period_max      <= RST_PERIOD_MAX;
            r_cfg.high_min        <= RST_HIGH_MIN;
            r_cfg.high_max        <= RST_HIGH_MAX;
            r_cfg.deadband        <= RST_DEADBAND;
            r_cfg.timeout_limit   <= RST_TIMEOUT_LIMIT;
            r_cfg.duty_full_scale <= RST_DUTY_FULL_SCALE;
            r_cfg.fixed_duty_pct  <= RST_FIXED_DUTY_PCT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD_MIN:      r_cfg.period_min      <= i_cfg_data;
                CFG_PERIOD_MAX:      r_cfg.period_max      <= i_cfg_data;
                CFG_HIGH_MIN:        r_cfg.high_min        <= i_cfg_data;
                CFG_HIGH_MAX:        r_cfg.high_max        <= i_cfg_data;
                CFG_DEADBAND:        r_cfg.deadband        <= i_cfg_data;
                CFG_TIMEOUT_LIMIT:   r_cfg.timeout_limit   <= i_cfg_data;
                CFG_DUTY_FULL_SCALE: r_cfg.duty_full_scale <= i_cfg_data;
                CFG_FIXED_DUTY_PCT:  r_cfg.fixed_duty_pct  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    rpt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_period_seen  (i_period_seen),
        .i_period_ticks (i_period_ticks),
        .i_high_seen    (i_high_seen),
        .i_high_ticks   (i_high_ticks),
        .i_overcapture  (i_overcapture),
        .i_s1_adv       (w_s1_adv),
        .o_s1           (w_s1),
        .o_s1_valid     (w_s1_valid)
    );

    rpt_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s1       (w_s1),
        .i_s1_valid (w_s1_valid),
        .o_s1_adv   (w_s1_adv),
        .i_s3_adv   (w_out_en),
        .o_s3_meta  (w_s3_meta),
        .o_s3_quo   (w_s3_quo),
        .o_s3_valid (w_s3_valid)
    );

    assign w_out_en = !r_o_valid || i_ready;

    // saturate at full scale and resolve the duty operation
    assign w_sat = (w_s3_quo > {7'd0, r_cfg.duty_full_scale}) ? r_cfg.duty_full_scale
                                                              : w_s3_quo[15:0];
    always_comb begin
        case (w_s3_meta.op)
            DUTY_KEEP:  n_duty = r_o_duty;
            DUTY_ZERO:  n_duty = 16'd0;
            DUTY_SCALE: n_duty = w_sat;
            default:    n_duty = r_o_duty;
        endcase
    end

    // result register; duty holds across transactions as decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_duty  <= 16'd0;
        end else if (w_out_en) begin
            r_o_valid <= w_s3_valid;
            if (w_s3_valid) begin
                r_o_duty <= n_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && w_s3_valid) begin
            r_o_throttle <= w_s3_meta.throttle;
            r_o_lost     <= w_s3_meta.lost;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_throttle    = r_o_throttle;
    assign o_duty        = r_o_duty;
    assign o_signal_lost = r_o_lost;

    // no result survives a reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
